// ===== rtl/complementary_filter_attitude_unit_defines.svh =====
// Assertion macros for the attitude filter RTL.
`ifndef COMPLEMENTARY_FILTER_ATTITUDE_UNIT_DEFINES_SVH
`define COMPLEMENTARY_FILTER_ATTITUDE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/cfa_pkg.sv =====
package cfa_pkg;

    localparam int AXIS_W  = 16;
    localparam int RATE_W  = 16;
    localparam int ANGLE_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int PERIOD_W = 20;
    localparam int SUMSQ_W = 32;
    localparam int RAD_W   = 48;
    localparam int ROOT_W  = 24;
    localparam int CORD_W  = 28;
    localparam int ZACC_W  = 20;
    localparam int DELTA_W = 23;
    localparam int DIFF_W  = 34;
    localparam int CORD_STEPS = 17;

    localparam logic signed [ZACC_W-1:0] HALF_PI = 20'sd102944;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 32'sh7fffffff;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 32'sh80000000;

    typedef enum logic [0:0] {
        REG_BLEND_WEIGHT  = 1'b0,
        REG_SAMPLE_PERIOD = 1'b1
    } cfg_reg_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT,
        ST_CORD_GO,
        ST_CORD,
        ST_BLP_GO,
        ST_BLP,
        ST_BLR_GO,
        ST_BLR,
        ST_FINISH
    } state_t;

    function automatic logic signed [ZACC_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ZACC_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 20'sd51472;
                5'd1:  v = 20'sd30385;
                5'd2:  v = 20'sd16055;
                5'd3:  v = 20'sd8150;
                5'd4:  v = 20'sd4091;
                5'd5:  v = 20'sd2047;
                5'd6:  v = 20'sd1024;
                5'd7:  v = 20'sd512;
                5'd8:  v = 20'sd256;
                5'd9:  v = 20'sd128;
                5'd10: v = 20'sd64;
                5'd11: v = 20'sd32;
                5'd12: v = 20'sd16;
                5'd13: v = 20'sd8;
                5'd14: v = 20'sd4;
                5'd15: v = 20'sd2;
                5'd16: v = 20'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Rate times period is a Q.30 product; round half up to a 23-bit Q7.16 step.
    function automatic logic signed [DELTA_W-1:0] gyro_step(
        input logic signed [RATE_W-1:0] rate,
        input logic [PERIOD_W-1:0] period
    );
        logic signed [RATE_W+PERIOD_W:0] prod;
        begin
            prod = rate * $signed({1'b0, period});
            prod = prod + 37'sd8192;
            return prod[RATE_W+PERIOD_W:14];
        end
    endfunction

endpackage

// ===== rtl/cfa_isqrt.sv =====
module cfa_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cfa_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [cfa_pkg::ROOT_W-1:0] root
);
    import cfa_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W+2:0]   rem_sh, trial, rem_sub;
    logic                ge;

    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial   = {1'b0, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/cfa_cordic.sv =====
module cfa_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cfa_pkg::CORD_W-1:0] y_in,
    input  logic [cfa_pkg::ROOT_W-1:0]        x_in,
    output logic                              done,
    output logic signed [cfa_pkg::ZACC_W-1:0] angle
);
    import cfa_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic signed [CORD_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [ZACC_W-1:0] z_reg, z_next, step;
    logic                     pos;

    always_comb
    begin
        dx   = y_reg >>> cnt_reg;
        dy   = x_reg >>> cnt_reg;
        step = atan_lut(cnt_reg);
        pos  = (y_reg != '0) && !y_reg[CORD_W-1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            cnt_next = '0;
            x_next   = $signed({{(CORD_W-ROOT_W){1'b0}}, x_in});
            y_next   = y_in;
            z_next   = '0;
            if (y_in == '0)
            begin
                done_next = 1'b1;
            end
            else if (x_in == '0)
            begin
                z_next    = y_in[CORD_W-1] ? -HALF_PI : HALF_PI;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            x_next   = pos ? x_reg + dx : x_reg - dx;
            y_next   = pos ? y_reg - dy : y_reg + dy;
            z_next   = pos ? z_reg + step : z_reg - step;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(CORD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

// ===== rtl/cfa_blend.sv =====
module cfa_blend (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [cfa_pkg::WEIGHT_W-1:0]       weight,
    input  logic signed [cfa_pkg::DIFF_W-1:0]  diff,
    input  logic signed [cfa_pkg::ZACC_W-1:0]  acc,
    output logic                               done,
    output logic signed [cfa_pkg::ANGLE_W-1:0] result
);
    import cfa_pkg::*;

    localparam int PROD_W = DIFF_W + WEIGHT_W;
    localparam int SUM_W  = PROD_W + 1;

    logic                      busy_reg, busy_next;
    logic                      fin_reg, fin_next;
    logic                      done_reg, done_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic [WEIGHT_W-1:0]       w_reg, w_next;
    logic signed [DIFF_W-1:0]  d_reg, d_next;
    logic signed [ZACC_W-1:0]  a_reg, a_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ANGLE_W-1:0] res_reg, res_next;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-17:0]  shifted;

    always_comb
    begin
        sum = SUM_W'(prod_reg) + (SUM_W'(a_reg) <<< 16) + SUM_W'(32768);
        shifted = sum[SUM_W-1:16];
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        w_next    = w_reg;
        d_next    = d_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            w_next    = weight;
            d_next    = diff;
            a_next    = acc;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            prod_next = (prod_reg <<< 1) + (w_reg[WEIGHT_W-1] ? PROD_W'(d_reg) : '0);
            w_next    = {w_reg[WEIGHT_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'(WEIGHT_W - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (shifted[SUM_W-17:ANGLE_W-1] == '0
                || shifted[SUM_W-17:ANGLE_W-1] == '1)
                res_next = shifted[ANGLE_W-1:0];
            else
                res_next = shifted[SUM_W-17] ? ANGLE_MIN : ANGLE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        d_reg    <= d_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/complementary_filter_attitude_unit.sv =====
// Channel    Dir  Fields (lowest bits first)
// s_axis     in   accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
// m_axis     out  roll_out, pitch_out, yaw_out
// cfg        in   blend_weight (index 0), sample_period (index 1)
//
// A sample passes from acceptance through idle and squaring, the bit-pair square root,
// the 17-step CORDIC and two passes of the bit-serial blend multiplier, then a finish
// state. When the pitch tilt has a zero numerator or a zero magnitude its CORDIC ends
// at once. The finish cycle stalls only while an earlier result is still waiting;
// a waiting result does not keep the next sample from being accepted.
// Reset clears the angles to zero and loads the default weight and period.
`include "complementary_filter_attitude_unit_defines.svh"
module complementary_filter_attitude_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // roll_out, pitch_out, yaw_out
    output logic [95:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_wdata
);
    import cfa_pkg::*;

    state_t state_reg, state_next;

    logic [WEIGHT_W-1:0]       weight_reg;
    logic [PERIOD_W-1:0]       period_reg;
    logic signed [AXIS_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [RATE_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic [SUMSQ_W-1:0]        sq_p_reg, sq_r_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                      m_valid_reg;
    logic [95:0]               m_data_reg;

    logic signed [ANGLE_W-1:0] sq_ax, sq_ay, sq_az;
    logic                      in_fire, root_go, cord_go, blend_go, out_load;
    logic                      p_root_done, r_root_done, p_cord_done, r_cord_done;
    logic [ROOT_W-1:0]         p_root, r_root;
    logic signed [ZACC_W-1:0]  p_acc, r_acc, bl_acc;
    logic signed [CORD_W-1:0]  p_y, r_y;
    logic signed [AXIS_W:0]    neg_ax;
    logic signed [DIFF_W-1:0]  bl_diff;
    logic                      bl_done;
    logic signed [ANGLE_W-1:0] bl_result;
    logic signed [ANGLE_W:0]   yaw_sum;
    logic signed [ANGLE_W-1:0] yaw_sat;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_ROOT_GO;
            ST_ROOT_GO: state_next = ST_ROOT;
            ST_ROOT:    if (p_root_done) state_next = ST_CORD_GO;
            ST_CORD_GO: state_next = ST_CORD;
            ST_CORD:    if (p_cord_done) state_next = ST_BLP_GO;
            ST_BLP_GO:  state_next = ST_BLP;
            ST_BLP:     if (bl_done) state_next = ST_BLR_GO;
            ST_BLR_GO:  state_next = ST_BLR;
            ST_BLR:     if (bl_done) state_next = ST_FINISH;
            ST_FINISH:  if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        root_go  = 1'b0;
        cord_go  = 1'b0;
        blend_go = 1'b0;
        out_load = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:    s_axis_tready = 1'b1;
            ST_ROOT_GO: root_go = 1'b1;
            ST_CORD_GO: cord_go = 1'b1;
            ST_BLP_GO, ST_BLR_GO: blend_go = 1'b1;
            ST_FINISH:  out_load = !m_valid_reg || m_axis_tready;
            default:    s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            weight_reg <= 16'd62259;
            period_reg <= 20'd10082;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BLEND_WEIGHT:  weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                    REG_SAMPLE_PERIOD: period_reg <= cfg_wdata;
                    default:           weight_reg <= weight_reg;
                endcase
            end
        end
    end

    assign sq_ax = ax_reg * ax_reg;
    assign sq_ay = ay_reg * ay_reg;
    assign sq_az = az_reg * az_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg <= s_axis_tdata[15:0];
            ay_reg <= s_axis_tdata[31:16];
            az_reg <= s_axis_tdata[47:32];
            rx_reg <= s_axis_tdata[63:48];
            ry_reg <= s_axis_tdata[79:64];
            rz_reg <= s_axis_tdata[95:80];
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_p_reg <= $unsigned(sq_ax) + $unsigned(sq_az);
            sq_r_reg <= $unsigned(sq_ay) + $unsigned(sq_az);
            dx_reg   <= gyro_step(rx_reg, period_reg);
            dy_reg   <= gyro_step(ry_reg, period_reg);
            dz_reg   <= gyro_step(rz_reg, period_reg);
        end
        if (out_load)
            m_data_reg <= {yaw_reg, pitch_reg, roll_reg};
    end

    cfa_isqrt u_root_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_go),
        .radicand ({sq_p_reg, 16'h0000}),
        .done     (p_root_done),
        .root     (p_root)
    );

    cfa_isqrt u_root_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_go),
        .radicand ({sq_r_reg, 16'h0000}),
        .done     (r_root_done),
        .root     (r_root)
    );

    assign neg_ax = -$signed({ax_reg[AXIS_W-1], ax_reg});
    assign p_y = $signed({{(CORD_W-AXIS_W-8){ay_reg[AXIS_W-1]}}, ay_reg, 8'h00});
    assign r_y = $signed({{(CORD_W-AXIS_W-9){neg_ax[AXIS_W]}}, neg_ax, 8'h00});

    cfa_cordic u_cord_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_go),
        .y_in  (p_y),
        .x_in  (p_root),
        .done  (p_cord_done),
        .angle (p_acc)
    );

    cfa_cordic u_cord_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_go),
        .y_in  (r_y),
        .x_in  (r_root),
        .done  (r_cord_done),
        .angle (r_acc)
    );

    always_comb
    begin
        if (state_reg == ST_BLP_GO)
        begin
            bl_acc  = p_acc;
            bl_diff = DIFF_W'(pitch_reg) + DIFF_W'(dx_reg) - DIFF_W'(p_acc);
        end
        else
        begin
            bl_acc  = r_acc;
            bl_diff = DIFF_W'(roll_reg) + DIFF_W'(dy_reg) - DIFF_W'(r_acc);
        end
    end

    cfa_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blend_go),
        .weight (weight_reg),
        .diff   (bl_diff),
        .acc    (bl_acc),
        .done   (bl_done),
        .result (bl_result)
    );

    assign yaw_sum = (ANGLE_W + 1)'(yaw_reg) + (ANGLE_W + 1)'(dz_reg);
    assign yaw_sat = (yaw_sum[ANGLE_W] == yaw_sum[ANGLE_W-1]) ? yaw_sum[ANGLE_W-1:0]
                   : (yaw_sum[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_BLP && bl_done)
                pitch_reg <= bl_result;
            if (state_reg == ST_BLR && bl_done)
            begin
                roll_reg <= bl_result;
                yaw_reg  <= yaw_sat;
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `CFA_ASSERT_NXT(a_accept_starts, clk, rst_n, in_fire, state_reg == ST_SQUARE)
    `CFA_ASSERT_IMP(a_roots_align, clk, rst_n, 1'b1, p_root_done == r_root_done)
    `CFA_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == ST_IDLE)
    `CFA_ASSERT_IMP(a_out_from_finish, clk, rst_n, $rose(m_axis_tvalid), $past(state_reg == ST_FINISH))

endmodule

// ===== dv/testbench.sv =====
module testbench;

    import cfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_PER_SET = 206;
    localparam longint HALF_PI_RAD = 102944;
    localparam longint ARCTAN_Q16 [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
                                           512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    typedef struct packed {
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } imu_sample_t;

    typedef struct packed {
        logic signed [31:0] yaw;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
    } attitude_t;

    typedef struct {
        imu_sample_t sample;
        bit          typed;
        attitude_t   attitude;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [19:0] cfg_wdata;

    complementary_filter_attitude_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    attitude_t   attitude_q[$];
    longint      gyro_weight;
    longint      step_period;
    logic signed [31:0] roll_est;
    logic signed [31:0] pitch_est;
    logic signed [31:0] yaw_est;
    int          errors;
    int          samples_sent;
    int          results_seen;
    int          idle_cycles;
    int          out_stall;
    bit          sender_idles;
    bit          receiver_idles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint tilt_angle(longint num, longint p, longint q);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(int_sqrt(longint'(p * p + q * q) << 16));
        y = num * 256;
        z = 0;
        if (y == 0)
            return 0;
        if (x == 0)
            return (y > 0) ? HALF_PI_RAD : -HALF_PI_RAD;
        for (int i = 0; i < 17; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return ANGLE_MAX;
        if (v < -64'sd2147483648)
            return ANGLE_MIN;
        return v[31:0];
    endfunction

    function automatic longint rate_delta(logic signed [15:0] rate);
        return (longint'(rate) * step_period + 8192) >>> 14;
    endfunction

    function automatic logic signed [31:0] blend_angle(logic signed [31:0] angle,
                                                       longint delta, longint acc);
        longint g;
        g = longint'(angle) + delta;
        return clamp32((gyro_weight * g + (65536 - gyro_weight) * acc + 32768) >>> 16);
    endfunction

    function automatic attitude_t update_attitude(imu_sample_t s);
        attitude_t a;
        longint pitch_tilt;
        longint roll_tilt;
        pitch_tilt = tilt_angle(s.accel_y, s.accel_x, s.accel_z);
        roll_tilt  = tilt_angle(-longint'(s.accel_x), s.accel_y, s.accel_z);
        yaw_est    = clamp32(longint'(yaw_est) + rate_delta(s.rate_z));
        pitch_est  = blend_angle(pitch_est, rate_delta(s.rate_x), pitch_tilt);
        roll_est   = blend_angle(roll_est, rate_delta(s.rate_y), roll_tilt);
        a.roll  = roll_est;
        a.pitch = pitch_est;
        a.yaw   = yaw_est;
        return a;
    endfunction

    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(imu_sample_t s, bit typed, attitude_t typed_att);
        int gap;
        attitude_t a;
        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= s;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        a = update_attitude(s);
        attitude_q.push_back(typed ? typed_att : a);
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (attitude_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [19:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == REG_BLEND_WEIGHT)
            gyro_weight = value[15:0];
        else
            step_period = value;
    endtask

    always @(posedge clk)
    begin
        int next_stall;
        logic next_ready;
        if (rst_n)
        begin
            next_stall = out_stall;
            if (m_axis_tvalid && m_axis_tready)
                next_stall = receiver_idles ? $urandom_range(0, 11) : 0;
            else if (next_stall > 0)
                next_stall--;
            next_ready = (next_stall == 0);
            out_stall <= next_stall;
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        attitude_t got;
        attitude_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("complementary_filter_attitude_unit: mismatch");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                results_seen++;
                if (attitude_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result transaction %h", got);
                end
                else
                begin
                    want = attitude_q.pop_front();
                    if (got.roll !== want.roll || got.pitch !== want.pitch ||
                        got.yaw !== want.yaw)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("Result %0d: expected roll %0d pitch %0d yaw %0d,",
                                     results_seen, want.roll, want.pitch, want.yaw);
                            $display("    got roll %0d pitch %0d yaw %0d",
                                     got.roll, got.pitch, got.yaw);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        table_row_t rows[$];
        table_row_t row;
        imu_sample_t s;
        attitude_t none;
        logic [15:0] weights[5];
        logic [19:0] periods[5];

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_BLEND_WEIGHT;
        cfg_wdata      = '0;
        errors         = 0;
        samples_sent   = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        out_stall      = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        gyro_weight    = 62259;
        step_period    = 10082;
        roll_est       = '0;
        pitch_est      = '0;
        yaw_est        = '0;
        none           = '0;

        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '0});
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '0});
        rows.push_back('{'{0, 0, 0, 0, 16'sd100, 0}, 1'b0, '0});
        rows.push_back('{'{0, 0, 0, 0, -16'sd100, 0}, 1'b0, '0});
        rows.push_back('{'{0, 0, 0, 16'sd500, 0, 0}, 1'b0, '0});
        rows.push_back('{'{0, 0, 0, -16'sd500, 0, 0}, 1'b0, '0});
        rows.push_back('{'{0, 0, 16'sd16384, 0, 0, 0}, 1'b0, '0});
        rows.push_back('{'{0, 0, -16'sd16384, 0, 0, 0}, 1'b0, '0});
        rows.push_back('{'{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
                         1'b0, '0});
        rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
                         1'b0, '0});
        rows.push_back('{'{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
                         1'b0, '0});
        rows.push_back('{'{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
                         1'b0, '0});
        rows.push_back('{'{0, 16'sd1, 0, 0, 0, 0}, 1'b0, '0});
        rows.push_back('{'{16'sd1, 0, 0, 0, 0, 0}, 1'b0, '0});
        rows.push_back('{'{-16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1}, 1'b0, '0});
        rows.push_back('{'{16'sd1000, -16'sd2000, 16'sd16000, 16'sd3, -16'sd7, 16'sd9},
                         1'b0, '0});
        rows.push_back('{'{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
                         1'b0, '0});
        rows.push_back('{'{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555},
                         1'b0, '0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_sample(row.sample, row.typed, row.attitude);
        end
        wait_idle();

        weights = '{16'd65535, 16'd0, 16'd32768, 16'd1, 16'($urandom)};
        periods = '{20'hfffff, 20'd1, 20'd0, 20'd10082, 20'($urandom_range(1, 20'hfffff))};

        foreach (weights[p])
        begin
            write_reg(REG_BLEND_WEIGHT, {4'd0, weights[p]});
            write_reg(REG_SAMPLE_PERIOD, periods[p]);
            cfg_wr_en <= 1'b0;
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < RANDOM_PER_SET; n++)
            begin
                s.accel_x = pick_field();
                s.accel_y = pick_field();
                s.accel_z = pick_field();
                s.rate_x  = pick_field();
                s.rate_y  = pick_field();
                s.rate_z  = pick_field();
                send_sample(s, 1'b0, none);
            end
            wait_idle();
        end

        if (attitude_q.size() != 0)
            errors++;
        $display("Sent %0d IMU samples and checked %0d attitude results",
                 samples_sent, results_seen);
        $display("over %0d register settings, weights 0 to 65535 and periods 0 to the maximum.",
                 6);
        if (errors == 0)
            $display("complementary_filter_attitude_unit: match");
        else
            $display("complementary_filter_attitude_unit: mismatch");
        $finish;
    end

endmodule
